// ===== sv/mfrg_pkg.sv =====
// Shared types and constants of the memory fill random generator.
`default_nettype none

package mfrg_pkg;

  // Splitmix64 seeding constants
  localparam logic [63:0] GOLDEN_STEP = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_MUL_1   = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_MUL_2   = 64'h94d049bb133111eb;

  // Fill mode register codes
  localparam logic [1:0] MODE_ONES = 2'd0;
  localparam logic [1:0] MODE_ZERO = 2'd1;
  localparam logic [1:0] MODE_RAND = 2'd2;
  localparam logic [1:0] MODE_NONE = 2'd3;

  // Input action codes
  localparam logic ACT_RESEED = 1'b0;
  localparam logic ACT_FILL   = 1'b1;

  // Constant fill bytes
  localparam logic [7:0] FILL_ONES = 8'hFF;
  localparam logic [7:0] FILL_ZERO = 8'h00;

  // Datapath operations
  typedef enum logic [3:0] {
    DP_NOP,
    DP_SEED,
    DP_PRE,
    DP_MUL0,
    DP_MUL1,
    DP_MUL2,
    DP_MIX,
    DP_FIN,
    DP_EMIT_ONES,
    DP_EMIT_ZERO,
    DP_EMIT_RAND
  } dp_op_t;

  // Command from controller to datapath
  typedef struct packed {
    dp_op_t op;
    logic   mul_sel;   // 0 first mix multiplier, 1 second
    logic   word_sel;  // 0 store into word a, 1 into word b
  } mfrg_cmd_t;

endpackage

`default_nettype wire

// ===== sv/memory_fill_random_generator.sv =====
// Top level of the memory fill random generator: register port, controller and datapath.
//
// Usage:
//   Input words (in_action, in_seed_value, in_byte_count) are taken when in_valid is high
//   and in_stall is low. A reseed word loads both 64-bit generator words through two
//   splitmix64 rounds and gives no output. A fill word gives min(in_byte_count, MAX_BURST)
//   output words (out_fill_byte, out_last_byte), the last one flagged.
//   A reseed keeps in_stall high through both rounds, so no word is taken meanwhile;
//   the shared 32x32 multiplier builds each 64-bit product from three partial products.
//   A fill enters the emit state once taken; there each byte is registered into the
//   output word, one byte per cycle while out_stall is low, and the next input word is
//   taken only after the last byte is loaded. A fill with a count of zero, or with
//   fill_mode 3, is taken and gives nothing. When the receiver stalls, the output word
//   holds and the burst pauses. Reset (rst_n low, synchronous) clears fill_mode to 0 and
//   both generator words to zero. fill_mode sits at byte address 0 of the register port;
//   the user must write it only while idle, as the block does not enforce this.
`default_nettype none

module memory_fill_random_generator #(
  parameter int MAX_BURST = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // Input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_action,
  input  wire logic [31:0] in_seed_value,
  input  wire logic [6:0]  in_byte_count,
  // Output channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_fill_byte,
  output logic             out_last_byte
);
  import mfrg_pkg::*;

  localparam logic [2:0] ADDR_FILL_MODE = 3'd0;

  logic [1:0] fill_mode_r, fill_mode_nxt;
  logic       reg_write;
  mfrg_cmd_t  cmd;

  // Register write decode
  assign reg_write = psel && penable && pwrite && pready;

  always_comb begin
    fill_mode_nxt = fill_mode_r;
    if (reg_write && paddr == ADDR_FILL_MODE) begin
      fill_mode_nxt = pwdata[1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_mode_r <= MODE_ONES;
    end else begin
      fill_mode_r <= fill_mode_nxt;
    end
  end

  // Read back
  assign prdata = (paddr == ADDR_FILL_MODE) ? {30'd0, fill_mode_r} : 32'd0;
  assign pready = 1'b1;

  mfrg_ctrl #(
    .MAX_BURST (MAX_BURST)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_action     (in_action),
    .in_byte_count (in_byte_count),
    .in_stall      (in_stall),
    .fill_mode     (fill_mode_r),
    .out_valid     (out_valid),
    .out_last_byte (out_last_byte),
    .out_stall     (out_stall),
    .cmd           (cmd)
  );

  mfrg_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_seed_value (in_seed_value),
    .out_fill_byte (out_fill_byte)
  );

endmodule

`default_nettype wire

// ===== sv/mfrg_datapath.sv =====
// Datapath: generator words, splitmix64 seeding with a shared 32x32 multiplier, fill byte.
`default_nettype none

module mfrg_datapath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire mfrg_pkg::mfrg_cmd_t cmd,
  input  wire logic [31:0]       in_seed_value,
  output logic [7:0]             out_fill_byte
);
  import mfrg_pkg::*;

  logic [63:0] word_a_r, word_a_nxt;
  logic [63:0] word_b_r, word_b_nxt;
  logic [63:0] x_r, x_nxt;
  logic [63:0] z_r, z_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [7:0]  byte_r, byte_nxt;

  logic [63:0] mul_const;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic [63:0] gen_sum;
  logic [63:0] gen_bx;
  logic [63:0] gen_a_nxt;
  logic [63:0] gen_b_nxt;
  logic [63:0] fin_val;

  // Select multiplier halves for the three partial products
  assign mul_const = cmd.mul_sel ? MIX_MUL_2 : MIX_MUL_1;
  assign mul_a     = (cmd.op == DP_MUL1) ? z_r[63:32] : z_r[31:0];
  assign mul_b     = (cmd.op == DP_MUL2) ? mul_const[63:32] : mul_const[31:0];
  assign prod      = 64'(mul_a) * 64'(mul_b);

  // xoroshiro128+ step
  assign gen_sum   = word_a_r + word_b_r;
  assign gen_bx    = word_a_r ^ word_b_r;
  assign gen_a_nxt = {word_a_r[8:0], word_a_r[63:9]} ^ gen_bx ^ (gen_bx << 14);
  assign gen_b_nxt = {gen_bx[27:0], gen_bx[63:28]};

  // Final splitmix64 scramble
  assign fin_val = acc_r ^ (acc_r >> 31);

  always_comb begin
    word_a_nxt = word_a_r;
    word_b_nxt = word_b_r;
    x_nxt      = x_r;
    z_nxt      = z_r;
    acc_nxt    = acc_r;
    byte_nxt   = byte_r;
    unique case (cmd.op)
      DP_SEED: begin
        x_nxt = {32'd0, in_seed_value} + GOLDEN_STEP;
      end
      DP_PRE: begin
        z_nxt = x_r ^ (x_r >> 30);
      end
      DP_MUL0: begin
        acc_nxt = prod;
      end
      DP_MUL1, DP_MUL2: begin
        acc_nxt[63:32] = acc_r[63:32] + prod[31:0];
      end
      DP_MIX: begin
        z_nxt = acc_r ^ (acc_r >> 27);
      end
      DP_FIN: begin
        if (cmd.word_sel) begin
          word_b_nxt = fin_val;
        end else begin
          word_a_nxt = fin_val;
        end
        x_nxt = x_r + GOLDEN_STEP;
      end
      DP_EMIT_ONES: begin
        byte_nxt = FILL_ONES;
      end
      DP_EMIT_ZERO: begin
        byte_nxt = FILL_ZERO;
      end
      DP_EMIT_RAND: begin
        byte_nxt   = gen_sum[7:0];
        word_a_nxt = gen_a_nxt;
        word_b_nxt = gen_b_nxt;
      end
      default: begin
      end
    endcase
  end

  // Generator words reset to zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_a_r <= '0;
      word_b_r <= '0;
    end else begin
      word_a_r <= word_a_nxt;
      word_b_r <= word_b_nxt;
    end
  end

  // Working registers and output byte
  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    z_r    <= z_nxt;
    acc_r  <= acc_nxt;
    byte_r <= byte_nxt;
  end

  assign out_fill_byte = byte_r;

endmodule

`default_nettype wire

// ===== sv/mfrg_ctrl.sv =====
// Controller: sequences reseeding and fill bursts, owns the output word valid and last flags.
`default_nettype none

module mfrg_ctrl #(
  parameter int MAX_BURST = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_action,
  input  wire logic [6:0]          in_byte_count,
  output logic                     in_stall,
  input  wire logic [1:0]          fill_mode,
  output logic                     out_valid,
  output logic                     out_last_byte,
  input  wire logic                out_stall,
  output mfrg_pkg::mfrg_cmd_t      cmd
);
  import mfrg_pkg::*;

  localparam int CNT_W = $clog2(MAX_BURST + 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRE,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_MIX,
    ST_FIN,
    ST_EMIT
  } state_t;

  state_t           state_r, state_nxt;
  logic             mul_sel_r, mul_sel_nxt;
  logic             round_r, round_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_last_r, out_last_nxt;
  logic [CNT_W-1:0] sat_count;
  logic             accept;
  logic             out_free;

  assign accept    = in_valid && (state_r == ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign sat_count = (in_byte_count > 7'(MAX_BURST)) ? CNT_W'(MAX_BURST)
                                                      : CNT_W'(in_byte_count);

  always_comb begin
    state_nxt     = state_r;
    mul_sel_nxt   = mul_sel_r;
    round_nxt     = round_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_last_nxt  = out_last_r;
    cmd.op        = DP_NOP;
    cmd.mul_sel   = mul_sel_r;
    cmd.word_sel  = round_r;

    // Drop the output word once it is taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_action == ACT_RESEED) begin
            cmd.op      = DP_SEED;
            round_nxt   = 1'b0;
            mul_sel_nxt = 1'b0;
            state_nxt   = ST_PRE;
          end else begin
            cnt_nxt = sat_count;
            if (sat_count != '0 && fill_mode != MODE_NONE) begin
              state_nxt = ST_EMIT;
            end
          end
        end
      end
      ST_PRE: begin
        cmd.op    = DP_PRE;
        state_nxt = ST_MUL0;
      end
      ST_MUL0: begin
        cmd.op    = DP_MUL0;
        state_nxt = ST_MUL1;
      end
      ST_MUL1: begin
        cmd.op    = DP_MUL1;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.op = DP_MUL2;
        if (mul_sel_r) begin
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_MIX;
        end
      end
      ST_MIX: begin
        cmd.op      = DP_MIX;
        mul_sel_nxt = 1'b1;
        state_nxt   = ST_MUL0;
      end
      ST_FIN: begin
        cmd.op      = DP_FIN;
        mul_sel_nxt = 1'b0;
        if (round_r) begin
          state_nxt = ST_IDLE;
        end else begin
          round_nxt = 1'b1;
          state_nxt = ST_PRE;
        end
      end
      ST_EMIT: begin
        // Load one byte into the output word whenever the slot is free
        if (out_free) begin
          case (fill_mode)
            MODE_ONES: cmd.op = DP_EMIT_ONES;
            MODE_ZERO: cmd.op = DP_EMIT_ZERO;
            default:   cmd.op = DP_EMIT_RAND;
          endcase
          out_valid_nxt = 1'b1;
          out_last_nxt  = (cnt_r == CNT_W'(1));
          cnt_nxt       = cnt_r - CNT_W'(1);
          if (cnt_r == CNT_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mul_sel_r   <= 1'b0;
      round_r     <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mul_sel_r   <= mul_sel_nxt;
      round_r     <= round_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  assign in_stall      = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_last_byte = out_last_r;

endmodule

`default_nettype wire
